[hw/rtl/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg: shared definitions for the C subset lexer
// Token kinds, scan modes, the keyword table and the keyword lookup.
// ----------------------------------------------------------------------------
package csl_pkg;

   localparam int DEF_MAX_LINE        = 4096;
   localparam int DEF_MAX_KEYWORD_LEN = 8;
   localparam int QUEUE_DEPTH         = 4;

   localparam int KW_COUNT = 14;
   localparam int KW_CHARS = 8;

   localparam logic [2:0] KIND_SEP   = 3'd0;
   localparam logic [2:0] KIND_OP    = 3'd1;
   localparam logic [2:0] KIND_NUM   = 3'd2;
   localparam logic [2:0] KIND_CALL  = 3'd3;
   localparam logic [2:0] KIND_KW    = 3'd4;
   localparam logic [2:0] KIND_IDENT = 3'd5;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_NUM  = 3'b010,
      MODE_WORD = 3'b100
   } mode_type;

   // Keyword text, right-justified, first character in the highest used byte.
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("int"), 64'("float"), 64'("double"), 64'("char"), 64'("if"),
      64'("else"), 64'("for"), 64'("while"), 64'("return"), 64'("void"),
      64'("break"), 64'("continue"), 64'("switch"), 64'("case")
   };
   localparam int KW_SIZE [KW_COUNT] = '{3, 5, 6, 4, 2, 4, 3, 5, 6, 4, 5, 8, 6, 4};

   // Returns {hit, index}. chars[j] is the j-th character of the word.
   function automatic logic [4:0] kw_lookup(input logic [KW_CHARS-1:0][7:0] chars,
                                            input logic short_word,
                                            input logic [3:0] len);
      logic        hit;
      logic [3:0]  idx;
      logic        same;
      logic [63:0] txt;
      hit = 1'b0;
      idx = 4'd0;
      for (int k = 0; k < KW_COUNT; k++) begin
         txt  = KW_TEXT[k] << (8 * (KW_CHARS - KW_SIZE[k]));
         same = short_word && (len == 4'(KW_SIZE[k]));
         for (int j = 0; j < KW_CHARS; j++) begin
            if (j < KW_SIZE[k] && chars[j] != txt[63 - 8*j -: 8]) begin
               same = 1'b0;
            end
         end
         if (same && !hit) begin
            hit = 1'b1;
            idx = 4'(k);
         end
      end
      return {hit, idx};
   endfunction

endpackage

[hw/rtl/csl_scan.sv]
// ----------------------------------------------------------------------------
// csl_scan: character scanner
// Holds the pending token and line position and turns one character into
// zero, one or two finished tokens in the same cycle.
// ----------------------------------------------------------------------------
module csl_scan import csl_pkg::*; #(
   parameter int MAX_LINE        = DEF_MAX_LINE,
   parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN,
   parameter int PW              = $clog2(MAX_LINE),
   parameter int LW              = $clog2(MAX_LINE) + 1,
   parameter int TW              = 15 + PW + LW
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  logic [7:0]    char_in,
   input  logic          end_of_line,
   output logic [TW:0]   tok_a,      // {last, keyword, length, start, symbol, kind}
   output logic [TW:0]   tok_b,
   output logic [1:0]    tok_cnt
);

   localparam int IW = $clog2(MAX_KEYWORD_LEN);

   mode_type        mode_ff, mode_in, mode_mid;
   logic [PW-1:0]   line_ff, line_in;
   logic [PW-1:0]   start_ff, start_in;
   logic [LW-1:0]   len_ff, len_in, len_sat;
   logic [7:0]      word_ff [MAX_KEYWORD_LEN];
   logic [7:0]      word_in [MAX_KEYWORD_LEN];

   logic [TW-1:0]   e1, e2, e3;
   logic            e1v, e2v, e3v;
   logic            used;
   logic [KW_CHARS-1:0][7:0] cur_chars, nxt_chars;
   logic [4:0]      kw_cur, kw_nxt;

   logic is_dig, is_alpha, is_word, is_sep, is_op;

   function automatic logic [TW-1:0] make_tok(input logic [2:0] kind,
                                              input logic [7:0] sym,
                                              input logic [PW-1:0] start,
                                              input logic [LW-1:0] len,
                                              input logic [3:0] kw);
      return {kw, len, start, sym, kind};
   endfunction

   assign is_dig   = (char_in >= "0") && (char_in <= "9");
   assign is_alpha = ((char_in >= "a") && (char_in <= "z")) ||
                     ((char_in >= "A") && (char_in <= "Z"));
   assign is_word  = is_alpha || is_dig || (char_in == "_");
   assign is_sep   = (char_in == "(") || (char_in == ")") || (char_in == "{") ||
                     (char_in == "}") || (char_in == "[") || (char_in == "]") ||
                     (char_in == ",") || (char_in == ";");
   assign is_op    = (char_in == "+") || (char_in == "-") || (char_in == "*") ||
                     (char_in == "/") || (char_in == "=") || (char_in == "<") ||
                     (char_in == ">") || (char_in == "!") || (char_in == "%");

   assign len_sat = (len_ff < LW'(MAX_LINE)) ? len_ff + 1'b1 : len_ff;

   always_comb begin
      for (int j = 0; j < KW_CHARS; j++) begin
         cur_chars[j] = word_ff[j];
      end
      kw_cur = kw_lookup(cur_chars, len_ff <= LW'(KW_CHARS), len_ff[3:0]);
   end

   always_comb begin
      e1v      = 1'b0;
      e2v      = 1'b0;
      e3v      = 1'b0;
      e1       = '0;
      e2       = '0;
      e3       = '0;
      used     = 1'b0;
      mode_mid = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      word_in  = word_ff;

      unique case (mode_ff)
         MODE_NUM: begin
            if (is_dig || char_in == ".") begin
               used   = 1'b1;
               len_in = len_sat;
            end else begin
               e1v      = 1'b1;
               e1       = make_tok(KIND_NUM, 8'd0, start_ff, len_ff, 4'd0);
               mode_mid = MODE_IDLE;
            end
         end
         MODE_WORD: begin
            if (is_word) begin
               used   = 1'b1;
               len_in = len_sat;
               if (len_ff < LW'(MAX_KEYWORD_LEN)) begin
                  word_in[len_ff[IW-1:0]] = char_in;
               end
            end else if (char_in == "(") begin
               // A call swallows its opening parenthesis.
               used     = 1'b1;
               e1v      = 1'b1;
               e1       = make_tok(KIND_CALL, 8'd0, start_ff, len_ff, 4'd0);
               mode_mid = MODE_IDLE;
            end else begin
               e1v      = 1'b1;
               e1       = kw_cur[4] ? make_tok(KIND_KW, 8'd0, start_ff, len_ff, kw_cur[3:0])
                                    : make_tok(KIND_IDENT, 8'd0, start_ff, len_ff, 4'd0);
               mode_mid = MODE_IDLE;
            end
         end
         default: ;
      endcase

      if (!used) begin
         if (is_sep) begin
            e2v = 1'b1;
            e2  = make_tok(KIND_SEP, char_in, line_ff, LW'(1), 4'd0);
         end else if (is_op) begin
            e2v = 1'b1;
            e2  = make_tok(KIND_OP, char_in, line_ff, LW'(1), 4'd0);
         end else if (is_dig || is_alpha || char_in == "_") begin
            mode_mid   = is_dig ? MODE_NUM : MODE_WORD;
            start_in   = line_ff;
            len_in     = LW'(1);
            word_in[0] = char_in;
         end
      end

      for (int j = 0; j < KW_CHARS; j++) begin
         nxt_chars[j] = word_in[j];
      end
      kw_nxt = kw_lookup(nxt_chars, len_in <= LW'(KW_CHARS), len_in[3:0]);

      mode_in = mode_mid;
      if (end_of_line) begin
         line_in = '0;
         if (mode_mid == MODE_NUM) begin
            e3v = 1'b1;
            e3  = make_tok(KIND_NUM, 8'd0, start_in, len_in, 4'd0);
         end else if (mode_mid == MODE_WORD) begin
            e3v = 1'b1;
            e3  = kw_nxt[4] ? make_tok(KIND_KW, 8'd0, start_in, len_in, kw_nxt[3:0])
                            : make_tok(KIND_IDENT, 8'd0, start_in, len_in, 4'd0);
         end
         mode_in = MODE_IDLE;
      end else if (line_ff < PW'(MAX_LINE - 1)) begin
         line_in = line_ff + 1'b1;
      end else begin
         line_in = line_ff;
      end
   end

   // At most two of the three emit points fire for one character.
   always_comb begin
      logic [TW-1:0] first, second;
      first   = e1v ? e1 : (e2v ? e2 : e3);
      second  = (e1v && e2v) ? e2 : e3;
      tok_cnt = 2'(e1v) + 2'(e2v) + 2'(e3v);
      tok_a   = {tok_cnt == 2'd1, first};
      tok_b   = {1'b1, second};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= '0;
         start_ff <= '0;
         len_ff   <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         word_ff <= word_in;
      end
   end

   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      fire && end_of_line |=> mode_ff == MODE_IDLE && line_ff == '0)
      else $error("line end left a pending token or position");

   a_two_max: assert property (@(posedge clock) disable iff (reset)
      !(e1v && e2v && e3v))
      else $error("more than two tokens from one character");

   a_pending_len: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_IDLE |-> len_ff != '0)
      else $error("pending token with zero length");

   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      line_ff <= PW'(MAX_LINE - 1))
      else $error("line position beyond the line limit");

endmodule

[hw/rtl/csl_queue.sv]
// ----------------------------------------------------------------------------
// csl_queue: token queue
// Small register queue that takes up to two tokens a cycle and hands out one.
// ----------------------------------------------------------------------------
module csl_queue import csl_pkg::*; #(
   parameter int WIDTH = 41,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_cnt,
   input  logic [WIDTH-1:0] push_a,
   input  logic [WIDTH-1:0] push_b,
   output logic             room,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [CW-1:0]    count_ff, count_in;
   logic             pop;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign room      = count_ff <= CW'(DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = bump(wr_ff);

   always_comb begin
      unique case (push_cnt)
         2'd0:    wr_in = wr_ff;
         2'd1:    wr_in = wr_next;
         default: wr_in = bump(wr_next);
      endcase
      rd_in    = pop ? bump(rd_ff) : rd_ff;
      count_in = count_ff + CW'(push_cnt) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ff] <= push_a;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_next] <= push_b;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd0 |-> CW'(push_cnt) + count_ff <= CW'(DEPTH))
      else $error("token queue overflow");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> count_ff == $past(count_ff) + CW'($past(push_cnt)) - CW'($past(pop)))
      else $error("token queue count mismatch");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("token queue count beyond depth");

endmodule

[hw/rtl/c_subset_lexer.sv]
// ----------------------------------------------------------------------------
// c_subset_lexer: streaming lexer for a small C subset
// One source character per input beat, tokens with start and length out.
// ----------------------------------------------------------------------------
// The lexer takes one character beat per clock cycle and scans it in that
// same cycle; each beat yields zero, one or two token beats, which wait in a
// four-entry queue in front of the result port. req_tready is high while the
// queue has two free entries, so input flows at one beat per cycle as long as
// the result side keeps up; the single result port hands out one token at a
// time, so it sets the rate over long runs of beats that yield two tokens.
// Results appear in the cycle after the beat that causes them at the
// earliest. A beat with tlast set ends the line: a pending number or word is
// flushed and the position counter returns to zero. The token kind travels
// on rsp_tuser.
module c_subset_lexer import csl_pkg::*; #(
   parameter int MAX_LINE        = DEF_MAX_LINE,
   parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN,
   parameter int PW              = $clog2(MAX_LINE),
   parameter int LW              = $clog2(MAX_LINE) + 1,
   parameter int RSP_W           = ((12 + PW + LW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // char_in
   input  logic             req_tlast,   // end_of_line
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // symbol, token_start, token_length, keyword_index, zero fill
   output logic [RSP_W-1:0] rsp_tdata,
   output logic [2:0]       rsp_tuser,   // token_kind
   output logic             rsp_tlast    // last_of_run
);

   localparam int TW = 15 + PW + LW;

   logic          fire;
   logic [TW:0]   tok_a, tok_b, head;
   logic [1:0]    tok_cnt, push_cnt;
   logic          room;

   assign req_tready = room;
   assign fire       = req_tvalid && room;
   assign push_cnt   = fire ? tok_cnt : 2'd0;

   csl_scan #(
      .MAX_LINE        (MAX_LINE),
      .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
      .PW              (PW),
      .LW              (LW),
      .TW              (TW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .char_in     (req_tdata),
      .end_of_line (req_tlast),
      .tok_a       (tok_a),
      .tok_b       (tok_b),
      .tok_cnt     (tok_cnt)
   );

   csl_queue #(
      .WIDTH (TW + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_a    (tok_a),
      .push_b    (tok_b),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = RSP_W'(head[TW-1:3]);
   assign rsp_tuser = head[2:0];
   assign rsp_tlast = head[TW];

endmodule
